[rtl/core/dels_pkg.sv]
// ----------------------------------------------------------------------------
// dels_pkg
// Shared codes and beat types for the double-ended list store.
// ----------------------------------------------------------------------------
package dels_pkg;

   // Payload width of one stored entry
   localparam int VALUE_W  = 32;
   localparam int MODE_W   = 3;
   localparam int STATUS_W = 2;

   // Operation codes carried on req_mode
   localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
   localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_LIST_ALL   = 3'd4;

   // Status codes carried on rsp_status
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   // One result beat offered by the sequencer to the output register
   typedef struct packed {
      logic                       valid;
      logic signed [VALUE_W-1:0]  value;
      logic [STATUS_W-1:0]        status;
      logic                       last;
   } emit_type;

   // Sequencer status seen by the top level
   typedef struct packed {
      logic busy;
      logic list_active;
   } ctrl_status_type;

endpackage

[rtl/core/double_ended_list_store_unit.sv]
// ----------------------------------------------------------------------------
// double_ended_list_store_unit
// Bounded double-ended list of signed 32-bit values kept in a ring memory.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel takes one operation per beat: push front, push back,
//   pop front, pop back or list all (req_mode), with req_value for pushes.
//   rsp_ channel returns result beats: rsp_value_res, rsp_status (ok, empty,
//   full) and rsp_last, set on the final beat of an operation.
//   Pushes and failed operations give their beat in the cycle after
//   acceptance. A pop reads the slot memory on acceptance and offers its
//   beat from the pop state, as the slot memory has a registered read.
//   A listing does one memory read per entry, one beat per cycle while
//   rsp_ready is high. Unused mode codes are accepted and give no beat.
//   One operation is worked on at a time; req_ready is low until the last
//   beat of the current one sits in the output register.
//   A stalled receiver holds the output register; the sequencer waits and
//   the memory read data is kept until the beat moves on.
//   Reset empties the list at once; no clearing pass is needed. Slots read
//   back only after they are written.
// ----------------------------------------------------------------------------
module double_ended_list_store_unit #(
   parameter int DEPTH = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [dels_pkg::MODE_W-1:0]          req_mode,
   input  logic signed [dels_pkg::VALUE_W-1:0]  req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [dels_pkg::VALUE_W-1:0]  rsp_value_res,
   output logic [dels_pkg::STATUS_W-1:0]        rsp_status,
   output logic                                 rsp_last
);

   localparam int IDX_W = $clog2(DEPTH);

   logic                              take;
   logic                              out_free;
   logic                              ram_wr_en;
   logic [IDX_W-1:0]                  ram_wr_addr;
   logic [dels_pkg::VALUE_W-1:0]      ram_wr_data;
   logic                              ram_rd_en;
   logic [IDX_W-1:0]                  ram_rd_addr;
   logic [dels_pkg::VALUE_W-1:0]      ram_rd_data;
   dels_pkg::emit_type                emit;
   dels_pkg::ctrl_status_type         status;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic signed [dels_pkg::VALUE_W-1:0] rsp_value_ff;
   logic [dels_pkg::STATUS_W-1:0]     rsp_status_ff;
   logic                              rsp_last_ff;

   // Handshake: output slot free when empty or draining this cycle
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = !status.busy && out_free;
   assign take      = req_valid && req_ready;

   dels_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .req_mode    (req_mode),
      .req_value   (req_value),
      .out_free    (out_free),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .emit        (emit),
      .status      (status)
   );

   dels_ram #(
      .WIDTH (dels_pkg::VALUE_W),
      .DEPTH (DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Output register
   always_comb begin
      if (emit.valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit.valid) begin
         rsp_value_ff  <= emit.value;
         rsp_status_ff <= emit.status;
         rsp_last_ff   <= emit.last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value_res = rsp_value_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_last      = rsp_last_ff;

`ifndef NO_ASSERTIONS
   // A non-final listing beat is always followed straight on by the next one
   a_list_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_last_ff |=> rsp_valid_ff)
      else $error("listing beat stream broke before its last beat");

   // Only a listing produces non-final beats
   a_nonlast_from_list: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_last_ff |-> status.list_active)
      else $error("non-final beat outside a listing");

   // Once a final beat is waiting the sequencer has finished
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |-> !status.busy)
      else $error("sequencer busy while a final beat is pending");
`endif

endmodule

[rtl/core/dels_ram.sv]
// ----------------------------------------------------------------------------
// dels_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module dels_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/dels_ctrl.sv]
// ----------------------------------------------------------------------------
// dels_ctrl
// Ring pointer state and operation sequencer: decodes one request, drives the
// slot memory and offers result beats to the output register.
// ----------------------------------------------------------------------------
module dels_ctrl #(
   parameter int DEPTH = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 take,
   input  logic [dels_pkg::MODE_W-1:0]          req_mode,
   input  logic signed [dels_pkg::VALUE_W-1:0]  req_value,
   input  logic                                 out_free,
   output logic                                 ram_wr_en,
   output logic [$clog2(DEPTH)-1:0]             ram_wr_addr,
   output logic [dels_pkg::VALUE_W-1:0]         ram_wr_data,
   output logic                                 ram_rd_en,
   output logic [$clog2(DEPTH)-1:0]             ram_rd_addr,
   input  logic [dels_pkg::VALUE_W-1:0]         ram_rd_data,
   output dels_pkg::emit_type                   emit,
   output dels_pkg::ctrl_status_type            status
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = IDX_W + 1;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_POP  = 3'b010,
      S_LIST = 3'b100
   } state_type;

   state_type        state_ff,  state_in;
   logic [IDX_W-1:0] front_ff,  front_in;
   logic [CNT_W-1:0] count_ff,  count_in;
   logic [IDX_W-1:0] ptr_ff,    ptr_in;
   logic [CNT_W-1:0] rem_ff,    rem_in;

   logic [IDX_W-1:0] front_dec;
   logic [IDX_W-1:0] front_inc;
   logic [IDX_W-1:0] ptr_inc;
   logic [SUM_W-1:0] back_sum;
   logic [SUM_W-1:0] tail_sum;
   logic [IDX_W-1:0] back_pos;
   logic [IDX_W-1:0] tail_pos;
   logic             is_full;
   logic             is_empty;

   // Fold a sum below twice the depth back into the ring
   function automatic logic [IDX_W-1:0] wrap_pos(input logic [SUM_W-1:0] s);
      logic [SUM_W-1:0] t;
      if (s >= SUM_W'(DEPTH)) begin
         t = s - SUM_W'(DEPTH);
      end else begin
         t = s;
      end
      return t[IDX_W-1:0];
   endfunction

   // Step one slot forward round the ring
   function automatic logic [IDX_W-1:0] step_pos(input logic [IDX_W-1:0] p);
      if (p == IDX_W'(DEPTH - 1)) begin
         return '0;
      end
      return p + IDX_W'(1);
   endfunction

   // Ring positions
   assign front_dec = (front_ff == '0) ? IDX_W'(DEPTH - 1) : front_ff - IDX_W'(1);
   assign front_inc = step_pos(front_ff);
   assign ptr_inc   = step_pos(ptr_ff);
   assign back_sum  = SUM_W'(front_ff) + SUM_W'(count_ff);
   assign tail_sum  = back_sum - SUM_W'(1);
   assign back_pos  = wrap_pos(back_sum);
   assign tail_pos  = wrap_pos(tail_sum);
   assign is_full   = (count_ff == CNT_W'(DEPTH));
   assign is_empty  = (count_ff == '0);

   assign ram_wr_data = req_value;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      front_in     = front_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      rem_in       = rem_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = front_dec;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = front_ff;
      emit.valid   = 1'b0;
      emit.value   = '0;
      emit.status  = dels_pkg::STATUS_OK;
      emit.last    = 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (take) begin
               case (req_mode)
                  dels_pkg::MODE_PUSH_FRONT: begin
                     emit.valid = 1'b1;
                     if (is_full) begin
                        emit.status = dels_pkg::STATUS_FULL;
                     end else begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = front_dec;
                        front_in    = front_dec;
                        count_in    = count_ff + CNT_W'(1);
                     end
                  end
                  dels_pkg::MODE_PUSH_BACK: begin
                     emit.valid = 1'b1;
                     if (is_full) begin
                        emit.status = dels_pkg::STATUS_FULL;
                     end else begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = back_pos;
                        count_in    = count_ff + CNT_W'(1);
                     end
                  end
                  dels_pkg::MODE_POP_FRONT: begin
                     if (is_empty) begin
                        emit.valid  = 1'b1;
                        emit.status = dels_pkg::STATUS_EMPTY;
                     end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = front_ff;
                        front_in    = front_inc;
                        count_in    = count_ff - CNT_W'(1);
                        state_in    = S_POP;
                     end
                  end
                  dels_pkg::MODE_POP_BACK: begin
                     if (is_empty) begin
                        emit.valid  = 1'b1;
                        emit.status = dels_pkg::STATUS_EMPTY;
                     end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = tail_pos;
                        count_in    = count_ff - CNT_W'(1);
                        state_in    = S_POP;
                     end
                  end
                  dels_pkg::MODE_LIST_ALL: begin
                     if (is_empty) begin
                        emit.valid  = 1'b1;
                        emit.status = dels_pkg::STATUS_EMPTY;
                     end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = front_ff;
                        ptr_in      = front_inc;
                        rem_in      = count_ff;
                        state_in    = S_LIST;
                     end
                  end
                  default: begin
                     // unused codes: no beat, no state change
                  end
               endcase
            end
         end
         S_POP: begin
            if (out_free) begin
               emit.valid = 1'b1;
               emit.value = ram_rd_data;
               state_in   = S_IDLE;
            end
         end
         S_LIST: begin
            if (out_free) begin
               emit.valid = 1'b1;
               emit.value = ram_rd_data;
               emit.last  = (rem_ff == CNT_W'(1));
               if (rem_ff == CNT_W'(1)) begin
                  state_in = S_IDLE;
               end else begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = ptr_ff;
                  ptr_in      = ptr_inc;
                  rem_in      = rem_ff - CNT_W'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign status.busy        = (state_ff != S_IDLE);
   assign status.list_active = (state_ff == S_LIST);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         front_ff <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         front_ff <= front_in;
         count_ff <= count_in;
      end
   end

   // Listing walk registers
   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      rem_ff <= rem_in;
   end

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the double-ended list store. A predictor mirrors
// the ring, the front slot and the fill level, works out the result beats of
// every accepted request and checks each returned beat field by field, in
// order. Directed edge cases come first, then a fill-to-full and drain pass,
// then random operation mixes under three sender/receiver idling profiles.
// ----------------------------------------------------------------------------
module testbench;

   localparam int STORE_DEPTH = 64;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 100;

   // One expected result beat
   typedef struct packed {
      logic signed [dels_pkg::VALUE_W-1:0] value;
      logic [dels_pkg::STATUS_W-1:0]       status;
      logic                                last;
   } result_beat_type;

   logic                                 clock;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_ready;
   logic [dels_pkg::MODE_W-1:0]          req_mode = dels_pkg::MODE_PUSH_FRONT;
   logic signed [dels_pkg::VALUE_W-1:0]  req_value = '0;
   logic                                 rsp_valid;
   logic                                 rsp_ready = 1'b0;
   logic signed [dels_pkg::VALUE_W-1:0]  rsp_value_res;
   logic [dels_pkg::STATUS_W-1:0]        rsp_status;
   logic                                 rsp_last;

   // Predictor state
   logic signed [dels_pkg::VALUE_W-1:0]  ring_store [STORE_DEPTH];
   logic [5:0]                           head_slot = '0;
   logic [6:0]                           fill_level = '0;
   result_beat_type                      pending_beats [$];
   result_beat_type                      oldest_beat;

   // Idling profile, in percent
   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;

   // Run statistics
   int unsigned cycle_count = 0;
   int unsigned error_count = 0;
   int unsigned requests_sent = 0;
   int unsigned beats_checked = 0;
   int unsigned full_hits = 0;
   int unsigned empty_hits = 0;
   int unsigned longest_listing = 0;

   double_ended_list_store_unit #(
      .DEPTH(STORE_DEPTH)
   ) i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_mode      (req_mode),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_value_res (rsp_value_res),
      .rsp_status    (rsp_status),
      .rsp_last      (rsp_last)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d beats outstanding",
                  cycle_count, pending_beats.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   // Receiver: random back-pressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_beats.size() == 0) begin
            $error("unexpected result beat: value %0d status %0d last %0d",
                   rsp_value_res, rsp_status, rsp_last);
            error_count++;
         end else begin
            oldest_beat = pending_beats.pop_front();
            beats_checked++;
            if (rsp_value_res !== oldest_beat.value) begin
               $error("rsp_value_res mismatch: expected %0d, got %0d",
                      oldest_beat.value, rsp_value_res);
               error_count++;
            end
            if (rsp_status !== oldest_beat.status) begin
               $error("rsp_status mismatch: expected %0d, got %0d",
                      oldest_beat.status, rsp_status);
               error_count++;
            end
            if (rsp_last !== oldest_beat.last) begin
               $error("rsp_last mismatch: expected %0d, got %0d",
                      oldest_beat.last, rsp_last);
               error_count++;
            end
         end
      end
   end

   // Queue one expected beat
   function automatic void add_beat(input logic signed [dels_pkg::VALUE_W-1:0] value,
                                    input logic [dels_pkg::STATUS_W-1:0] status,
                                    input logic last);
      result_beat_type beat;
      beat.value  = value;
      beat.status = status;
      beat.last   = last;
      pending_beats.push_back(beat);
      if (status == dels_pkg::STATUS_FULL)  full_hits++;
      if (status == dels_pkg::STATUS_EMPTY) empty_hits++;
   endfunction

   // Predict the beats of one accepted request and update the mirror
   function automatic void predict_list_op(
      input logic [dels_pkg::MODE_W-1:0] mode,
      input logic signed [dels_pkg::VALUE_W-1:0] value);
      logic [5:0] slot;
      case (mode)
         dels_pkg::MODE_PUSH_FRONT, dels_pkg::MODE_PUSH_BACK: begin
            if (fill_level >= STORE_DEPTH) begin
               add_beat('0, dels_pkg::STATUS_FULL, 1'b1);
            end else begin
               if (mode == dels_pkg::MODE_PUSH_FRONT) begin
                  head_slot = head_slot - 6'd1;
                  slot = head_slot;
               end else begin
                  slot = head_slot + fill_level[5:0];
               end
               ring_store[slot] = value;
               fill_level = fill_level + 7'd1;
               add_beat('0, dels_pkg::STATUS_OK, 1'b1);
            end
         end
         dels_pkg::MODE_POP_FRONT, dels_pkg::MODE_POP_BACK: begin
            if (fill_level == 0) begin
               add_beat('0, dels_pkg::STATUS_EMPTY, 1'b1);
            end else begin
               if (mode == dels_pkg::MODE_POP_FRONT) begin
                  slot = head_slot;
                  head_slot = head_slot + 6'd1;
               end else begin
                  slot = head_slot + fill_level[5:0] - 6'd1;
               end
               add_beat(ring_store[slot], dels_pkg::STATUS_OK, 1'b1);
               fill_level = fill_level - 7'd1;
            end
         end
         dels_pkg::MODE_LIST_ALL: begin
            if (fill_level == 0) begin
               add_beat('0, dels_pkg::STATUS_EMPTY, 1'b1);
            end else begin
               for (int k = 0; k < fill_level; k++) begin
                  slot = head_slot + 6'(k);
                  add_beat(ring_store[slot], dels_pkg::STATUS_OK,
                           (k + 1 == fill_level));
               end
               if (fill_level > longest_listing) longest_listing = fill_level;
            end
         end
         default: ; // spare codes: no beat, no change
      endcase
   endfunction

   // Send one request beat; valid stays high across back-to-back beats
   task automatic send_request(input logic [dels_pkg::MODE_W-1:0] mode,
                               input logic signed [dels_pkg::VALUE_W-1:0] value);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_mode  <= mode;
      req_value <= value;
      do @(posedge clock); while (!req_ready);
      predict_list_op(mode, value);
      requests_sent++;
   endtask

   // Mostly random data, now and then an extreme
   function automatic logic signed [dels_pkg::VALUE_W-1:0] pick_value();
      case ($urandom_range(9))
         0: return {1'b1, {(dels_pkg::VALUE_W-1){1'b0}}};
         1: return {1'b0, {(dels_pkg::VALUE_W-1){1'b1}}};
         2: return '0;
         3: return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [dels_pkg::MODE_W-1:0] pick_push();
      return $urandom_range(1) ? dels_pkg::MODE_PUSH_BACK : dels_pkg::MODE_PUSH_FRONT;
   endfunction

   function automatic logic [dels_pkg::MODE_W-1:0] pick_pop();
      return $urandom_range(1) ? dels_pkg::MODE_POP_BACK : dels_pkg::MODE_POP_FRONT;
   endfunction

   // Pops and listing on an empty store
   task automatic test_empty_store();
      send_request(dels_pkg::MODE_POP_FRONT, pick_value());
      send_request(dels_pkg::MODE_POP_BACK, pick_value());
      send_request(dels_pkg::MODE_LIST_ALL, pick_value());
   endtask

   // Extreme values from both ends, listed and popped back out
   task automatic test_extreme_values();
      send_request(dels_pkg::MODE_PUSH_FRONT, {1'b1, {(dels_pkg::VALUE_W-1){1'b0}}});
      send_request(dels_pkg::MODE_PUSH_BACK, {1'b0, {(dels_pkg::VALUE_W-1){1'b1}}});
      send_request(dels_pkg::MODE_PUSH_BACK, '1);
      send_request(dels_pkg::MODE_PUSH_FRONT, '0);
      send_request(dels_pkg::MODE_LIST_ALL, '0);
      send_request(dels_pkg::MODE_POP_FRONT, '1);
      send_request(dels_pkg::MODE_POP_BACK, '0);
      send_request(dels_pkg::MODE_POP_BACK, '1);
      send_request(dels_pkg::MODE_POP_FRONT, '0);
      send_request(dels_pkg::MODE_LIST_ALL, '1);
   endtask

   // Spare mode codes must be swallowed without a beat
   task automatic test_unused_modes();
      for (int m = dels_pkg::MODE_LIST_ALL + 1; m < (1 << dels_pkg::MODE_W); m++) begin
         send_request(dels_pkg::MODE_W'(m), pick_value());
      end
   endtask

   // Fill to capacity, overflow at both ends, list everything, drain, then pop both ends once empty
   task automatic test_fill_and_drain();
      while (fill_level < STORE_DEPTH) send_request(pick_push(), pick_value());
      send_request(dels_pkg::MODE_PUSH_FRONT, pick_value());
      send_request(dels_pkg::MODE_PUSH_BACK, pick_value());
      send_request(dels_pkg::MODE_LIST_ALL, pick_value());
      while (fill_level > 0) send_request(pick_pop(), pick_value());
      send_request(dels_pkg::MODE_POP_FRONT, pick_value());
      send_request(dels_pkg::MODE_POP_BACK, pick_value());
   endtask

   // Random mix, mostly pushes and pops, some listings and spare codes
   task automatic test_random_mix(input int unsigned count);
      int unsigned roll;
      logic [dels_pkg::MODE_W-1:0] mode;
      for (int unsigned n = 0; n < count; n++) begin
         roll = $urandom_range(99);
         if (roll < 48)      mode = pick_push();
         else if (roll < 84) mode = pick_pop();
         else if (roll < 94) mode = dels_pkg::MODE_LIST_ALL;
         else                mode = dels_pkg::MODE_W'($urandom_range(
                                       dels_pkg::MODE_LIST_ALL + 1,
                                       (1 << dels_pkg::MODE_W) - 1));
         send_request(mode, pick_value());
      end
   endtask

   task automatic set_idling(input int unsigned send_pct, input int unsigned stall_pct);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
   endtask

   // Test sequence
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      set_idling(9, 53);
      test_empty_store();
      test_extreme_values();
      test_unused_modes();
      test_fill_and_drain();
      test_random_mix(55);

      set_idling(53, 9);
      test_random_mix(55);

      set_idling(0, 0);
      test_random_mix(55);
      req_valid <= 1'b0;

      // Let every outstanding beat arrive, then watch for strays
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d requests, checked %0d result beats, longest listing %0d",
               requests_sent, beats_checked, longest_listing);
      $display("Full store hits %0d, empty store hits %0d, mismatches %0d",
               full_hits, empty_hits, error_count);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

[double_ended_list_store_unit.f]
rtl/core/dels_pkg.sv
rtl/core/dels_ram.sv
rtl/core/dels_ctrl.sv
rtl/core/double_ended_list_store_unit.sv
bench/testbench.sv
